/* sv/annexb_pkg.sv */
`timescale 1ns / 1ps

package annexb_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 1048576;
  localparam int MAX_NAL_UNITS_DEF   = 64;

  localparam int ADDR_W  = 20;
  localparam int TOTAL_W = 21;
  localparam int LEN_W   = 21;

  localparam logic [LEN_W-1:0] LEN_SAT    = '1;
  localparam logic [7:0]       START_BYTE = 8'h01;
  localparam logic [1:0]       ZR_MAX     = 2'd3;

  localparam logic [4:0] AVC_SPS  = 5'd7;
  localparam logic [4:0] AVC_PPS  = 5'd8;
  localparam logic [5:0] HEVC_VPS = 6'd32;
  localparam logic [5:0] HEVC_SPS = 6'd33;
  localparam logic [5:0] HEVC_PPS = 6'd34;

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_HEADER,
    KIND_DONE
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_ZERO,
    PH_BYTE,
    PH_FLUSH,
    PH_CLOSE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          data;
    logic [TOTAL_W-1:0]  total;
    logic                ovf;
  } res_t;

  typedef struct packed {
    logic push;
    logic fin;
  } emit_t;

  function automatic logic is_param_set(logic hevc, logic [7:0] b);
    logic [5:0] t_hevc;
    logic [4:0] t_avc;
    t_hevc = b[6:1];
    t_avc  = b[4:0];
    if (hevc) begin
      return (t_hevc == HEVC_VPS) || (t_hevc == HEVC_SPS) || (t_hevc == HEVC_PPS);
    end
    return (t_avc == AVC_SPS) || (t_avc == AVC_PPS);
  endfunction

endpackage

/* sv/annexb_obuf.sv */
`timescale 1ns / 1ps

module annexb_obuf import annexb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  emit_t emit,
  input  res_t  res,
  output logic  gen_ok,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res,
  output logic  out_last
);

  logic hold_valid_r;
  logic hold_last_r;
  res_t hold_res_r;
  logic out_valid_r;
  res_t out_res_r;
  logic out_last_r;
  logic slot_free;
  logic hold_move;

  // hold stage keeps the newest beat until we know whether it ends its byte
  assign slot_free = !out_valid_r || out_ready;
  assign gen_ok    = !hold_valid_r || slot_free;
  assign hold_move = hold_valid_r && slot_free && (hold_last_r || emit.push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
      hold_last_r  <= 1'b0;
    end else begin
      if (hold_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit.push) begin
        hold_valid_r <= 1'b1;
        hold_last_r  <= emit.fin;
      end else if (hold_move) begin
        hold_valid_r <= 1'b0;
      end else if (emit.fin) begin
        hold_last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.push) begin
      hold_res_r <= res;
    end
    if (hold_move) begin
      out_res_r  <= hold_res_r;
      out_last_r <= hold_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

/* sv/annexb_core.sv */
`timescale 1ns / 1ps

module annexb_core import annexb_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  parameter int MAX_NAL_UNITS   = MAX_NAL_UNITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  input  logic       cfg_we,
  input  logic       cfg_hevc,
  input  logic       gen_ok,
  output emit_t      emit,
  output res_t       res
);

  localparam int PTR_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_NAL_UNITS + 1);
  localparam logic [PTR_W:0]   CAP     = (PTR_W + 1)'(MAX_FRAME_BYTES);
  localparam logic [IDX_W-1:0] NAL_LIM = IDX_W'(MAX_NAL_UNITS);

  logic             item_valid_r;
  logic [7:0]       byte_r;
  logic             end_r;
  phase_t           phase_r, phase_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             hevc_r;
  logic [1:0]       zr_r, zr_nxt;
  logic             in_stream_r, in_stream_nxt;
  logic             nal_open_r, nal_open_nxt;
  logic             nal_kept_r, nal_kept_nxt;
  logic [IDX_W-1:0] nal_index_r, nal_index_nxt;
  logic [PTR_W-1:0] header_addr_r, header_addr_nxt;
  logic [PTR_W-1:0] write_ptr_r, write_ptr_nxt;
  logic [LEN_W-1:0] nal_length_r, nal_length_nxt;
  logic             overflowed_r, overflowed_nxt;

  logic is_zero, is_start, hdr_due;
  logic fin;
  logic zr_inc, zr_dec, zr_clr, take_en, take_zero, start_en, nal_clr, hdr_en, done_en;

  logic [7:0]       take_val;
  logic             opening, active, kept_now, room;
  logic [PTR_W:0]   wp_sum;
  logic [PTR_W-1:0] wp_hdr, wp_base;
  logic [LEN_W-1:0] len_base;
  logic [PTR_W:0]   hdr_addr;
  logic [7:0]       len_byte;

  logic gen_v;
  res_t gen;
  logic step, load;

  assign is_zero  = byte_r == 8'h00;
  assign is_start = (byte_r == START_BYTE) && (zr_r >= 2'd2);
  assign hdr_due  = nal_open_r && nal_kept_r;

  // sequencing
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    fin       = 1'b0;
    case (phase_r)
      PH_HEAD: begin
        if (is_zero) begin
          if (end_r) phase_nxt = PH_FLUSH;
          else fin = 1'b1;
        end else if (is_start) begin
          if (hdr_due) begin
            phase_nxt = PH_CLOSE;
            cnt_nxt   = 2'd0;
          end else if (end_r) begin
            phase_nxt = PH_DONE;
          end else begin
            fin = 1'b1;
          end
        end else if (zr_r != 2'd0) begin
          phase_nxt = (zr_r == 2'd1) ? PH_BYTE : PH_ZERO;
        end else if (end_r) begin
          phase_nxt = PH_FLUSH;
        end else begin
          fin = 1'b1;
        end
      end
      PH_ZERO: begin
        if (zr_r == 2'd1) phase_nxt = PH_BYTE;
      end
      PH_BYTE: begin
        if (end_r) phase_nxt = PH_FLUSH;
        else fin = 1'b1;
      end
      PH_FLUSH: begin
        if (zr_r == 2'd0) begin
          if (hdr_due) begin
            phase_nxt = PH_CLOSE;
            cnt_nxt   = 2'd0;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_CLOSE: begin
        if (cnt_r == 2'd3) begin
          if (end_r) phase_nxt = PH_DONE;
          else fin = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      PH_DONE: begin
        fin = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
    if (fin) phase_nxt = PH_HEAD;
  end

  // per-phase controls
  always_comb begin
    zr_inc    = 1'b0;
    zr_dec    = 1'b0;
    zr_clr    = 1'b0;
    take_en   = 1'b0;
    take_zero = 1'b0;
    start_en  = 1'b0;
    nal_clr   = 1'b0;
    hdr_en    = 1'b0;
    done_en   = 1'b0;
    case (phase_r)
      PH_HEAD: begin
        if (is_zero) begin
          if (zr_r != ZR_MAX) zr_inc = 1'b1;
          else take_en = 1'b1;
        end else if (is_start) begin
          start_en = 1'b1;
          zr_clr   = 1'b1;
          nal_clr  = !hdr_due;
        end else if (zr_r != 2'd0) begin
          take_en   = 1'b1;
          take_zero = 1'b1;
          zr_dec    = 1'b1;
        end else begin
          take_en = 1'b1;
        end
      end
      PH_ZERO: begin
        take_en   = 1'b1;
        take_zero = 1'b1;
        zr_dec    = 1'b1;
      end
      PH_BYTE: begin
        take_en = 1'b1;
      end
      PH_FLUSH: begin
        if (zr_r != 2'd0) begin
          take_en   = 1'b1;
          take_zero = 1'b1;
          zr_dec    = 1'b1;
        end else begin
          nal_clr = !hdr_due;
        end
      end
      PH_CLOSE: begin
        hdr_en  = 1'b1;
        nal_clr = cnt_r == 2'd3;
      end
      PH_DONE: begin
        done_en = 1'b1;
      end
      default: begin
        done_en = 1'b0;
      end
    endcase
  end

  // one byte into the current NAL
  always_comb begin
    take_val = take_zero ? 8'h00 : byte_r;
    opening  = !nal_open_r;
    active   = take_en && in_stream_r && !(opening && (nal_index_r >= NAL_LIM));
    kept_now = opening ? !is_param_set(hevc_r, take_val) : nal_kept_r;
    wp_sum   = {1'b0, write_ptr_r} + (PTR_W + 1)'(4);
    wp_hdr   = (wp_sum > CAP) ? CAP[PTR_W-1:0] : wp_sum[PTR_W-1:0];
    wp_base  = (opening && kept_now) ? wp_hdr : write_ptr_r;
    len_base = opening ? '0 : nal_length_r;
    room     = {1'b0, wp_base} < CAP;
    hdr_addr = {1'b0, header_addr_r} + (PTR_W + 1)'(cnt_r);
    case (cnt_r)
      2'd0:    len_byte = 8'h00;
      2'd1:    len_byte = 8'(nal_length_r >> 16);
      2'd2:    len_byte = nal_length_r[15:8];
      default: len_byte = nal_length_r[7:0];
    endcase
  end

  // datapath
  always_comb begin
    zr_nxt          = zr_r;
    in_stream_nxt   = in_stream_r;
    nal_open_nxt    = nal_open_r;
    nal_kept_nxt    = nal_kept_r;
    nal_index_nxt   = nal_index_r;
    header_addr_nxt = header_addr_r;
    write_ptr_nxt   = write_ptr_r;
    nal_length_nxt  = nal_length_r;
    overflowed_nxt  = overflowed_r;
    gen_v           = 1'b0;
    gen             = '0;

    if (zr_inc) zr_nxt = zr_r + 2'd1;
    if (zr_dec) zr_nxt = zr_r - 2'd1;
    if (zr_clr) zr_nxt = 2'd0;
    if (start_en) in_stream_nxt = 1'b1;

    if (active) begin
      if (opening) begin
        nal_open_nxt  = 1'b1;
        nal_index_nxt = nal_index_r + IDX_W'(1);
        nal_kept_nxt  = kept_now;
        if (kept_now) header_addr_nxt = write_ptr_r;
      end
      if (kept_now) begin
        nal_length_nxt = (len_base < LEN_SAT) ? len_base + LEN_W'(1) : len_base;
        write_ptr_nxt  = wp_base;
        if (room) begin
          gen_v         = 1'b1;
          gen.kind      = KIND_PAYLOAD;
          gen.addr      = ADDR_W'(wp_base);
          gen.data      = take_val;
          write_ptr_nxt = wp_base + PTR_W'(1);
        end else begin
          overflowed_nxt = 1'b1;
        end
      end
    end

    if (nal_clr) begin
      nal_open_nxt   = 1'b0;
      nal_kept_nxt   = 1'b0;
      nal_length_nxt = '0;
    end

    if (hdr_en) begin
      if (hdr_addr < CAP) begin
        gen_v    = 1'b1;
        gen.kind = KIND_HEADER;
        gen.addr = ADDR_W'(hdr_addr);
        gen.data = len_byte;
      end else begin
        overflowed_nxt = 1'b1;
      end
    end

    if (done_en) begin
      gen_v           = 1'b1;
      gen.kind        = KIND_DONE;
      gen.total       = TOTAL_W'(write_ptr_r);
      gen.ovf         = overflowed_r;
      zr_nxt          = 2'd0;
      in_stream_nxt   = 1'b0;
      nal_open_nxt    = 1'b0;
      nal_kept_nxt    = 1'b0;
      nal_index_nxt   = '0;
      header_addr_nxt = '0;
      write_ptr_nxt   = '0;
      nal_length_nxt  = '0;
      overflowed_nxt  = 1'b0;
    end
  end

  assign step      = item_valid_r && (!gen_v || gen_ok);
  assign in_ready  = !item_valid_r || (step && fin);
  assign load      = in_valid && in_ready;
  assign emit.push = step && gen_v;
  assign emit.fin  = step && fin;
  assign res       = gen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r  <= 1'b0;
      phase_r       <= PH_HEAD;
      cnt_r         <= 2'd0;
      hevc_r        <= 1'b0;
      zr_r          <= 2'd0;
      in_stream_r   <= 1'b0;
      nal_open_r    <= 1'b0;
      nal_kept_r    <= 1'b0;
      nal_index_r   <= '0;
      header_addr_r <= '0;
      write_ptr_r   <= '0;
      nal_length_r  <= '0;
      overflowed_r  <= 1'b0;
    end else begin
      if (cfg_we) hevc_r <= cfg_hevc;
      if (load) begin
        item_valid_r <= 1'b1;
      end else if (step && fin) begin
        item_valid_r <= 1'b0;
      end
      if (step) begin
        phase_r       <= phase_nxt;
        cnt_r         <= cnt_nxt;
        zr_r          <= zr_nxt;
        in_stream_r   <= in_stream_nxt;
        nal_open_r    <= nal_open_nxt;
        nal_kept_r    <= nal_kept_nxt;
        nal_index_r   <= nal_index_nxt;
        header_addr_r <= header_addr_nxt;
        write_ptr_r   <= write_ptr_nxt;
        nal_length_r  <= nal_length_nxt;
        overflowed_r  <= overflowed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
      end_r  <= in_end;
    end
  end

`ifndef ASSERT_OFF
  a_phase_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEAD) |-> item_valid_r)
    else $error("sequencer left head phase without a byte");

  a_kept_open: assert property (@(posedge clk) disable iff (!rst_n)
    nal_kept_r |-> nal_open_r)
    else $error("kept NAL is not open");

  a_close_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CLOSE) |-> (nal_open_r && nal_kept_r))
    else $error("length write without an open kept NAL");

  a_ptr_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, write_ptr_r} <= CAP) && ({1'b0, header_addr_r} <= CAP))
    else $error("write pointer past capacity");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.push && (res.kind == KIND_DONE)) |-> emit.fin)
    else $error("frame done beat is not the last of its byte");
`endif

endmodule

/* sv/annexb_to_length_prefixed_nal_unit.sv */
`timescale 1ns / 1ps

// Annex-B to length-prefixed NAL converter for H.264/H.265, one input byte per beat.
// Each byte steps a small sequencer that does one sub-step per cycle unless the output
// buffer holds back a beat: a plain byte or a zero byte is handled in the head phase
// alone, so an unstalled steady stream runs at one byte per cycle; a byte after held
// zeros first releases each held zero (up to three); a start code that closes a kept
// NAL then writes the four length bytes; the frame-end byte also releases its held
// zeros, closes the NAL, writes the four length bytes of a kept NAL and sends the done
// beat. Output beats are writes to the frame buffer (tuser 0 payload, 1 length header)
// and one done beat (tuser 2) carrying the total length and overflow flag; tlast marks
// the last beat caused by an input byte; beats pass the hold and output registers.
// The output ready feeds the input ready combinationally through the sequencer.
// cfg_wr_data selects H.265 type rules and should be written between frames.

module annexb_to_length_prefixed_nal_unit import annexb_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  parameter int MAX_NAL_UNITS   = MAX_NAL_UNITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [19:0] write_addr, [27:20] write_byte,
                                  // [48:28] total_length, [49] overflow, [55:50] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  emit_t emit;
  res_t  res;
  res_t  out_res;
  logic  gen_ok;

  annexb_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .MAX_NAL_UNITS   (MAX_NAL_UNITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_end   (in_tlast),
    .cfg_we   (cfg_wr_en),
    .cfg_hevc (cfg_wr_data),
    .gen_ok   (gen_ok),
    .emit     (emit),
    .res      (res)
  );

  annexb_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .res       (res),
    .gen_ok    (gen_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'b0, out_res.ovf, out_res.total, out_res.data, out_res.addr};
  assign out_tuser = out_res.kind;

endmodule

/* tb/annexb_to_length_prefixed_nal_unit_chk.sv */
`timescale 1ns / 1ps

module annexb_to_length_prefixed_nal_unit_chk import annexb_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  parameter int MAX_NAL_UNITS   = MAX_NAL_UNITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int          errors,
  output int          pending,
  output int          beats,
  output int          frames,
  output int          overflow_frames
);

  localparam int LEN_MAX = (1 << LEN_W) - 1;

  typedef struct {
    kind_t              kind;
    logic [ADDR_W-1:0]  addr;
    logic [7:0]         data;
    logic [TOTAL_W-1:0] total;
    logic               ovf;
    logic               last;
  } buf_write_t;

  buf_write_t buf_writes_q[$];

  logic hevc_rules;
  int   held_zeros;
  logic synced;
  logic nal_active;
  logic nal_write;
  logic ovf_seen;
  int   nals_seen;
  int   hdr_slot;
  int   wr_ptr;
  int   nal_len;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic drops_nal(logic h265, logic [7:0] b);
    if (h265) return (b[6:1] >= HEVC_VPS) && (b[6:1] <= HEVC_PPS);
    return (b[4:0] == AVC_SPS) || (b[4:0] == AVC_PPS);
  endfunction

  function automatic void restart_frame();
    held_zeros = 0;
    synced     = 1'b0;
    nal_active = 1'b0;
    nal_write  = 1'b0;
    nals_seen  = 0;
    hdr_slot   = 0;
    wr_ptr     = 0;
    nal_len    = 0;
    ovf_seen   = 1'b0;
  endfunction

  function automatic void queue_write(kind_t k, int a, logic [7:0] d, int tot, logic o);
    buf_write_t w;
    w.kind  = k;
    w.addr  = a[ADDR_W-1:0];
    w.data  = d;
    w.total = tot[TOTAL_W-1:0];
    w.ovf   = o;
    w.last  = 1'b0;
    buf_writes_q.push_back(w);
  endfunction

  function automatic void feed_nal_byte(logic [7:0] b);
    if (!synced) return;
    if (!nal_active) begin
      if (nals_seen >= MAX_NAL_UNITS) return;
      nal_active = 1'b1;
      nals_seen++;
      nal_len   = 0;
      nal_write = !drops_nal(hevc_rules, b);
      if (nal_write) begin
        hdr_slot = wr_ptr;
        wr_ptr   = (wr_ptr + 4 > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : wr_ptr + 4;
      end
    end
    if (!nal_write) return;
    if (nal_len < LEN_MAX) nal_len++;
    if (wr_ptr < MAX_FRAME_BYTES) begin
      queue_write(KIND_PAYLOAD, wr_ptr, b, 0, 1'b0);
      wr_ptr++;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  function automatic void seal_nal();
    int          i;
    int          a;
    logic [31:0] len_be;
    len_be = nal_len;
    if (nal_active && nal_write) begin
      for (i = 0; i < 4; i++) begin
        a = hdr_slot + i;
        if (a < MAX_FRAME_BYTES) queue_write(KIND_HEADER, a, len_be[8*(3-i) +: 8], 0, 1'b0);
        else ovf_seen = 1'b1;
      end
    end
    nal_active = 1'b0;
    nal_write  = 1'b0;
    nal_len    = 0;
  endfunction

  function automatic void convert_byte(logic [7:0] b, logic fin);
    int         first;
    int         k;
    buf_write_t w;
    first = buf_writes_q.size();
    if (b == 8'h00) begin
      if (held_zeros < 3) held_zeros++;
      else feed_nal_byte(8'h00);
    end else if (b == START_BYTE && held_zeros >= 2) begin
      seal_nal();
      synced     = 1'b1;
      held_zeros = 0;
    end else begin
      for (k = 0; k < held_zeros; k++) feed_nal_byte(8'h00);
      held_zeros = 0;
      feed_nal_byte(b);
    end
    if (fin) begin
      for (k = 0; k < held_zeros; k++) feed_nal_byte(8'h00);
      held_zeros = 0;
      seal_nal();
      queue_write(KIND_DONE, 0, 8'h00, wr_ptr, ovf_seen);
      restart_frame();
    end
    if (buf_writes_q.size() > first) begin
      w = buf_writes_q.pop_back();
      w.last = 1'b1;
      buf_writes_q.push_back(w);
    end
  endfunction

  task automatic check_beat();
    buf_write_t w;
    if (buf_writes_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat tuser=%0d tdata=%h", out_tuser, out_tdata));
      return;
    end
    w = buf_writes_q.pop_front();
    if (out_tuser !== w.kind)
      report_mismatch($sformatf("beat %0d kind %0d, want %0d", beats, out_tuser, w.kind));
    if (out_tdata[19:0] !== w.addr)
      report_mismatch($sformatf("beat %0d addr %h, want %h", beats, out_tdata[19:0], w.addr));
    if (out_tdata[27:20] !== w.data)
      report_mismatch($sformatf("beat %0d byte %h, want %h", beats, out_tdata[27:20], w.data));
    if (out_tdata[48:28] !== w.total)
      report_mismatch($sformatf("beat %0d total %0d, want %0d", beats, out_tdata[48:28],
                                w.total));
    if (out_tdata[49] !== w.ovf)
      report_mismatch($sformatf("beat %0d overflow %b, want %b", beats, out_tdata[49], w.ovf));
    if (out_tdata[55:50] !== 6'd0)
      report_mismatch($sformatf("beat %0d pad bits %b not zero", beats, out_tdata[55:50]));
    if (out_tlast !== w.last)
      report_mismatch($sformatf("beat %0d tlast %b, want %b", beats, out_tlast, w.last));
    beats++;
    if (w.kind == KIND_DONE) begin
      frames++;
      if (w.ovf) overflow_frames++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hevc_rules = 1'b0;
      restart_frame();
      buf_writes_q.delete();
    end else begin
      if (cfg_wr_en) hevc_rules = cfg_wr_data;
      if (in_tvalid && in_tready) convert_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_beat();
    end
    pending = buf_writes_q.size();
  end

endmodule

/* tb/annexb_to_length_prefixed_nal_unit_tb.sv */
`timescale 1ns / 1ps

module annexb_to_length_prefixed_nal_unit_tb;
  import annexb_pkg::*;

  // a 1024-byte buffer, and a low NAL cap so the NAL limit is reachable
  localparam int FRAME_CAP    = 1024;
  localparam int NAL_CAP      = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_BYTES  = 40;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;

  int errors;
  int pending;
  int beats;
  int frames;
  int overflow_frames;

  int   cycles       = 0;
  int   bytes_sent   = 0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  int   hold_reqs    = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  logic cur_hevc     = 1'b0;

  logic [8:0] frame_q[$];  // {frame_end, data_byte}

  annexb_to_length_prefixed_nal_unit #(
    .MAX_FRAME_BYTES(FRAME_CAP),
    .MAX_NAL_UNITS  (NAL_CAP)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  annexb_to_length_prefixed_nal_unit_chk #(
    .MAX_FRAME_BYTES(FRAME_CAP),
    .MAX_NAL_UNITS  (NAL_CAP)
  ) u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .errors         (errors),
    .pending        (pending),
    .beats          (beats),
    .frames         (frames),
    .overflow_frames(overflow_frames)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // output side: random stalls plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen  <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic void add_byte(logic [7:0] b);
    frame_q.push_back({1'b0, b});
  endfunction

  function automatic void end_frame();
    logic [8:0] e;
    e = frame_q.pop_back();
    frame_q.push_back({1'b1, e[7:0]});
  endfunction

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'h00;
    if (r < 50) return 8'h01;
    if (r < 55) return 8'h03;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] nal_header(logic h265);
    int r;
    r = $urandom_range(5);
    if (r < 2 && h265)
      return {1'($urandom_range(1)), 6'($urandom_range(32, 34)), 1'($urandom_range(1))};
    if (r < 2)
      return {3'($urandom_range(7)), 5'($urandom_range(7, 8))};
    if (r == 2 && !h265)
      return {1'($urandom_range(1)), 6'($urandom_range(32, 34)), 1'($urandom_range(1))};
    if (r == 2)
      return {3'($urandom_range(7)), 5'($urandom_range(7, 8))};
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i][7:0], frame_q[i][8]);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_codec(input logic h265);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= h265;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_hevc  = h265;
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  task automatic build_stream();
    int n_nal;
    int k;
    int zeros;
    frame_q.delete();
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(2, 255)));
    n_nal = ($urandom_range(5) == 0) ? $urandom_range(NAL_CAP, NAL_CAP + 4)
                                     : $urandom_range(1, 4);
    for (k = 0; k < n_nal; k++) begin
      zeros = ($urandom_range(3) == 0) ? $urandom_range(3, 6) : $urandom_range(2, 3);
      repeat (zeros) add_byte(8'h00);
      add_byte(START_BYTE);
      if ($urandom_range(9) != 0) begin
        add_byte(nal_header(cur_hevc));
        repeat ($urandom_range(0, 10)) add_byte(payload_byte());
      end
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) add_byte(8'h00);
    end_frame();
  endtask

  task automatic build_noise();
    frame_q.delete();
    repeat ($urandom_range(1, 16)) add_byte(payload_byte());
    end_frame();
  endtask

  task automatic run_random(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      if ($urandom_range(7) == 0) build_noise();
      else build_stream();
      send_frame();
      if ($urandom_range(5) == 0) settle();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_codec(1'b0);
    set_idle(0, 0);
    // junk before sync, long zero run, empty NAL, dropped SPS, zeros held at end
    frame_q.delete();
    add_byte(8'hFF); add_byte(8'h01);
    add_byte(8'h00); add_byte(8'h00); add_byte(START_BYTE);
    add_byte(8'h65); add_byte(8'hFF);
    repeat (5) add_byte(8'h00);
    add_byte(START_BYTE);
    add_byte(8'h00); add_byte(8'h00); add_byte(START_BYTE);
    add_byte(8'h67); add_byte(8'h12);
    add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(START_BYTE);
    add_byte(8'h41); add_byte(8'h00); add_byte(8'h00);
    end_frame();
    send_frame();
    // frame with no start code at all
    frame_q.delete();
    add_byte(8'hFF);
    end_frame();
    send_frame();
    settle();

    set_codec(1'b1);
    set_idle(54, 0);
    run_random(PHASE_BYTES);
    settle();

    set_codec(1'b0);
    set_idle(0, 54);
    run_random(PHASE_BYTES);
    settle();

    set_codec(1'b1);
    set_idle(14, 14);
    run_random(PHASE_BYTES);
    settle();

    set_codec(1'b0);
    set_idle(0, 0);
    hold_reqs <= hold_reqs + 1;
    run_random(PHASE_BYTES);
    settle();

    set_codec(1'b1);
    set_idle(0, 0);
    run_random(PHASE_BYTES);
    settle();

    @(negedge clk);
    $display("Sent %0d bytes; checked %0d output beats over %0d frames, %0d of them overflowing.",
             bytes_sent, beats, frames, overflow_frames);
    $display("Both codec rule sets, idle and stall mixes, a %0d-cycle output hold, NAL cap %0d.",
             HOLD_CYCLES, NAL_CAP);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
